/* src/lb32_pkg.sv */
// shared types and constants for the lenient base32 decoder
// no dependencies; used by lb32_front, lb32_fifo, lb32_back and the top level
`default_nettype none

package lb32_pkg;

  // classified character class handed from the front to the back
  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_PAD,
    TK_SKIP,
    TK_BAD,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [4:0] digit;
  } tok_t;

  // result status codes
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // input kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // token queue depth
  localparam int unsigned QDEPTH = 2;

  // back-end state snapshot for monitoring
  typedef struct packed {
    logic        failed;
    logic [3:0]  pending;
    logic [15:0] bytes_out;
  } back_stat_t;

endpackage

`default_nettype wire

/* src/lb32_front.sv */
// front end: classifies each input beat into a decode token
// depends on lb32_pkg
`default_nettype none

module lb32_front (
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire logic               s_kind_i,
  input  wire logic [7:0]         s_ch_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output lb32_pkg::tok_t          push_tok_o
);

  logic [7:0] ch_map;
  logic       is_alpha;
  logic       is_num;
  logic       is_skip;
  logic [7:0] num_digit;

  always_comb begin
    // common look-alike characters: zero, one and eight
    case (s_ch_i)
      8'h30:   ch_map = 8'h4F;
      8'h31:   ch_map = 8'h4C;
      8'h38:   ch_map = 8'h42;
      default: ch_map = s_ch_i;
    endcase
    is_alpha  = (ch_map inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_num    = (ch_map inside {[8'h32:8'h37]});
    is_skip   = (s_ch_i inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2D});
    num_digit = ch_map - 8'h32 + 8'd26;

    push_tok_o.digit = 5'd0;
    if (s_kind_i == lb32_pkg::KIND_END) begin
      push_tok_o.kind = lb32_pkg::TK_END;
    end else if (s_ch_i == 8'h3D) begin
      push_tok_o.kind = lb32_pkg::TK_PAD;
    end else if (is_skip) begin
      push_tok_o.kind = lb32_pkg::TK_SKIP;
    end else if (is_alpha) begin
      push_tok_o.kind  = lb32_pkg::TK_DIGIT;
      push_tok_o.digit = ch_map[4:0] - 5'd1;
    end else if (is_num) begin
      push_tok_o.kind  = lb32_pkg::TK_DIGIT;
      push_tok_o.digit = num_digit[4:0];
    end else begin
      push_tok_o.kind = lb32_pkg::TK_BAD;
    end
  end

  assign push_valid_o = s_valid_i;
  assign s_ready_o    = push_ready_i;

endmodule

`default_nettype wire

/* src/lb32_fifo.sv */
// short token queue between front and back end
// depends on lb32_pkg
`default_nettype none

module lb32_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  wire lb32_pkg::tok_t     push_tok_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output lb32_pkg::tok_t          pop_tok_o
);

  localparam int unsigned PtrW = (lb32_pkg::QDEPTH > 1) ? $clog2(lb32_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(lb32_pkg::QDEPTH + 1);

  lb32_pkg::tok_t slot_q [lb32_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(lb32_pkg::QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_tok_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lb32_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lb32_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

`default_nettype wire

/* src/lb32_back.sv */
// back end: bit accumulator, padding and error tracking, output register
// depends on lb32_pkg
`default_nettype none

module lb32_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_valid_i,
  output logic                    pop_ready_o,
  input  wire lb32_pkg::tok_t     pop_tok_i,
  input  wire logic [15:0]        max_bytes_i,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [1:0]              m_status_o,
  output logic [7:0]              m_value_o,
  output logic [15:0]             m_count_o,
  output lb32_pkg::back_stat_t    stat_o
);

  logic [11:0] acc_q, acc_d;
  logic [3:0]  pend_q, pend_d;
  logic        pad_q, pad_d;
  logic [15:0] bytes_q, bytes_d;
  logic        failed_q, failed_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [7:0]  out_value_q, out_value_d;
  logic [15:0] out_count_q, out_count_d;

  logic        take;
  logic        full;
  logic [11:0] acc_sh;
  logic [3:0]  pend5;
  logic [3:0]  pend_sub;
  logic [2:0]  shamt;
  logic [11:0] acc_shr;

  assign pop_ready_o = !out_valid_q || m_ready_i;
  assign take        = pop_valid_i && pop_ready_o;
  assign full        = (bytes_q >= max_bytes_i);
  assign acc_sh      = {acc_q[6:0], pop_tok_i.digit};
  assign pend5       = pend_q + 4'd5;
  assign pend_sub    = pend5 - 4'd8;
  assign shamt       = pend_sub[2:0];
  assign acc_shr     = acc_sh >> shamt;

  always_comb begin
    acc_d        = acc_q;
    pend_d       = pend_q;
    pad_d        = pad_q;
    bytes_d      = bytes_q;
    failed_d     = failed_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;

    if (take) begin
      if (pop_tok_i.kind == lb32_pkg::TK_END) begin
        if (!failed_q) begin
          out_valid_d  = 1'b1;
          out_status_d = lb32_pkg::ST_DONE;
          out_value_d  = 8'd0;
          out_count_d  = bytes_q;
        end
        acc_d    = '0;
        pend_d   = '0;
        pad_d    = 1'b0;
        bytes_d  = '0;
        failed_d = 1'b0;
      end else if (!failed_q && !full) begin
        if (pop_tok_i.kind == lb32_pkg::TK_PAD) begin
          pend_d = (pend5 >= 4'd8) ? pend_sub : pend5;
          pad_d  = (pend_d != 4'd0);
        end else if (pad_q || pop_tok_i.kind == lb32_pkg::TK_BAD) begin
          failed_d     = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = lb32_pkg::ST_ERROR;
          out_value_d  = 8'd0;
          out_count_d  = bytes_q;
        end else if (pop_tok_i.kind == lb32_pkg::TK_DIGIT) begin
          acc_d = acc_sh;
          if (pend5 >= 4'd8) begin
            pend_d       = pend_sub;
            bytes_d      = bytes_q + 16'd1;
            out_valid_d  = 1'b1;
            out_status_d = lb32_pkg::ST_BYTE;
            out_value_d  = acc_shr[7:0];
            out_count_d  = bytes_d;
          end else begin
            pend_d = pend5;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pend_q      <= '0;
      pad_q       <= 1'b0;
      bytes_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      pad_q       <= pad_d;
      bytes_q     <= bytes_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_value_o  = out_value_q;
  assign m_count_o  = out_count_q;

  assign stat_o = '{failed: failed_q, pending: pend_q, bytes_out: bytes_q};

endmodule

`default_nettype wire

/* src/lenient_base32_decoder.sv */
// top level of the lenient base32 decoder: stream ports, max_bytes register
// depends on lb32_pkg, lb32_front, lb32_fifo and lb32_back
`default_nettype none

// Decodes a base32 text stream one character beat at a time and sustains one
// beat per clock on both sides unless the result side stalls. Each input beat
// carries a character in tdata (or an end-of-string mark when tuser is set);
// letters of either case, the digits 2-7, and 0/1/8 as O/L/B are data, while
// space, tab, CR, LF and hyphen are skipped. A decoded byte, an error or the
// end-of-string count comes out as one result beat with the status in tuser.
// An input beat is classified combinationally into the token queue, and the
// accumulator update is registered in the output register. The rate is set
// by the accumulator update in the back end; the two-entry token queue and
// the output register let either side stall on its own. After an error the
// rest of the string is dropped silently up to the end mark, which then gives
// no result. Once max_bytes bytes are out, further characters are ignored.
// The user must write max_bytes via cfg_we_i/cfg_wdata_i only while the
// decoder is idle; the block does not enforce this. max_bytes resets to 65535.

module lenient_base32_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  wire logic        s_axis_tuser_i,   // [0] kind
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [7:0] value, [23:8] byte_count
  output logic [1:0]       m_axis_tuser_o,   // [1:0] status
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  // capacity register
  logic [15:0] max_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      max_bytes_q <= cfg_wdata_i;
    end
  end

  // front end to queue
  logic           push_valid;
  logic           push_ready;
  lb32_pkg::tok_t push_tok;

  // queue to back end
  logic           pop_valid;
  logic           pop_ready;
  lb32_pkg::tok_t pop_tok;

  logic [1:0]  res_status;
  logic [7:0]  res_value;
  logic [15:0] res_count;
  lb32_pkg::back_stat_t back_stat;

  lb32_front u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_kind_i     (s_axis_tuser_i),
    .s_ch_i       (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_tok_o   (push_tok)
  );

  lb32_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_tok_i   (push_tok),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_tok_o    (pop_tok)
  );

  lb32_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_tok_i    (pop_tok),
    .max_bytes_i  (max_bytes_q),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_status_o   (res_status),
    .m_value_o    (res_value),
    .m_count_o    (res_count),
    .stat_o       (back_stat)
  );

  // pack result beat: value low, byte count above
  assign m_axis_tdata_o = {res_count, res_value};
  assign m_axis_tuser_o = res_status;

  // pending bit count always settles below one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pending <= 4'd7)
    else $error("pending bit count reached a full byte");

  // a byte result always carries a nonzero running count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == lb32_pkg::ST_BYTE) |-> (m_axis_tdata_o[23:8] != 16'd0))
    else $error("byte result with zero byte count");

  // an error result waiting at the output implies the string is marked failed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == lb32_pkg::ST_ERROR) |-> back_stat.failed)
    else $error("error result without failed flag");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench for the lenient base32 decoder: directed table, then random text strings
// depends on lb32_pkg and lenient_base32_decoder; checks every result beat against a predictor
`timescale 1ns / 100ps

module testbench;

  // one result beat as the decoder reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  value;
    logic [15:0] count;
  } b32_result_t;

  // one row of the directed table: the beat, and optionally its typed-in result
  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic        typed;   // result given in the row instead of predicted
    logic        has;     // typed row expects a result beat
    b32_result_t res;
  } text_row_t;

  localparam int DIR_N       = 26;
  localparam int SETTLE      = 4;     // cycles to wait once no result is due
  localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side

  // character codes the decoder treats specially
  localparam logic [7:0] CH_PAD   = "=";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TOP   = 8'hFF;

  // row tags
  localparam logic [1:0]  PRED   = 2'b00;  // predictor decides
  localparam logic [1:0]  NONE   = 2'b10;  // typed: no result beat
  localparam logic [1:0]  GOT    = 2'b11;  // typed: one result beat
  localparam b32_result_t NO_RES = '0;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [7:0]  s_data   = '0;
  logic        s_user   = 1'b0;
  logic        m_ready  = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [15:0] cfg_wdata = '0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [23:0] m_axis_tdata_o;
  wire  [1:0]  m_axis_tuser_o;

  text_row_t   row_tag = '0;  // tag of the beat on the bus, directed part only
  logic        quiet   = 1'b0; // no stalls on either side

  // predictor state
  logic [11:0] acc_bits  = '0;
  logic [3:0]  acc_count = '0;
  logic        in_pad    = 1'b0;
  logic [15:0] out_total = '0;
  logic        dropped   = 1'b0;
  logic [15:0] cap_bytes = 16'hFFFF;

  b32_result_t due_results [$];   // decoded results still to come out
  int          errors      = 0;
  int          idle_cycles = 0;
  int          live_items  = 0;   // input beats that the decoder did not ignore
  int          beats_in    = 0;
  int          n_bytes     = 0;
  int          n_done      = 0;
  int          n_err       = 0;

  logic [7:0] blank_chars [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_DASH};

  // directed table: reset value of max_bytes (65535) throughout
  text_row_t directed [DIR_N] = '{
    // "My======" decodes to 0x66: two digits, lower case, padding that closes
    {lb32_pkg::KIND_CHAR, "M",    PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, "y",    PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_END,  CH_NUL, GOT,  lb32_pkg::ST_DONE,  8'd0, 16'd1},
    // NUL is invalid; the rest of the string and its end give nothing
    {lb32_pkg::KIND_CHAR, CH_NUL, GOT,  lb32_pkg::ST_ERROR, 8'd0, 16'd0},
    {lb32_pkg::KIND_CHAR, "A",    NONE, NO_RES},
    {lb32_pkg::KIND_END,  CH_NUL, NONE, NO_RES},
    // top code is invalid too; end beat with all data bits set
    {lb32_pkg::KIND_CHAR, CH_TOP, GOT,  lb32_pkg::ST_ERROR, 8'd0, 16'd0},
    {lb32_pkg::KIND_END,  CH_TOP, NONE, NO_RES},
    // aliases 0/1/8 and digit 7, with tab, CR, LF and hyphen after them
    {lb32_pkg::KIND_CHAR, "0",    PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_TAB, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, "1",    PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_CR,  PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, "8",    PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_LF,  PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, "7",    PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_DASH, PRED, NO_RES},
    // four leftover bits are dropped at the end
    {lb32_pkg::KIND_END,  CH_NUL, GOT,  lb32_pkg::ST_DONE,  8'd0, 16'd2},
    // a skipped character inside padding is an error
    {lb32_pkg::KIND_CHAR, CH_PAD, PRED, NO_RES},
    {lb32_pkg::KIND_CHAR, CH_SPACE, GOT, lb32_pkg::ST_ERROR, 8'd0, 16'd0},
    {lb32_pkg::KIND_END,  CH_NUL, NONE, NO_RES}
  };

  lenient_base32_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // digit value of a character, bit 5 set when it is not a digit
  function automatic logic [5:0] b32_value(input logic [7:0] c);
    logic [7:0] a;
    a = c;
    if (c == "0") a = "O";
    else if (c == "1") a = "L";
    else if (c == "8") a = "B";
    if ((a >= "A" && a <= "Z") || (a >= "a" && a <= "z")) return {1'b0, a[4:0] - 5'd1};
    if (a >= "2" && a <= "7") return {1'b0, 5'(a - "2" + 8'd26)};
    return 6'b100000;
  endfunction

  // predictor: one accepted input beat, with its result beat if any
  task automatic decode_step(input logic kind, input logic [7:0] ch, output logic made,
                             output b32_result_t res, output logic live);
    logic [5:0] dv;
    logic [4:0] fill;
    made = 1'b0;
    res  = '0;
    live = 1'b1;
    if (kind == lb32_pkg::KIND_END) begin
      if (!dropped) begin
        made = 1'b1;
        res  = {lb32_pkg::ST_DONE, 8'd0, out_total};
      end
      acc_bits  = '0;
      acc_count = '0;
      in_pad    = 1'b0;
      out_total = '0;
      dropped   = 1'b0;
    end else if (dropped || out_total >= cap_bytes) begin
      live = 1'b0;
    end else if (ch == CH_PAD) begin
      // padding steps the bit count by 5 modulo 8 and closes at zero
      fill = {1'b0, acc_count} + 5'd5;
      if (fill >= 5'd8) fill = fill - 5'd8;
      acc_count = fill[3:0];
      in_pad    = (fill != 5'd0);
    end else begin
      dv = b32_value(ch);
      if (in_pad || (dv[5] && ch != CH_SPACE && ch != CH_TAB && ch != CH_CR &&
                     ch != CH_LF && ch != CH_DASH)) begin
        dropped = 1'b1;
        made    = 1'b1;
        res     = {lb32_pkg::ST_ERROR, 8'd0, out_total};
      end else if (!dv[5]) begin
        acc_bits = {acc_bits[6:0], dv[4:0]};
        fill     = {1'b0, acc_count} + 5'd5;
        if (fill >= 5'd8) begin
          fill      = fill - 5'd8;
          out_total = out_total + 16'd1;
          made      = 1'b1;
          res       = {lb32_pkg::ST_BYTE, 8'(acc_bits >> fill), out_total};
        end
        acc_count = fill[3:0];
      end
    end
  endtask

  task automatic flag_error(input string msg);
    errors++;
    $display("mismatch at %0t ns: %0s", $realtime, msg);
  endtask

  // both handshakes and the register write, seen at the rising edge
  always @(posedge clk_i) begin : monitor
    b32_result_t got, want, calc;
    logic        made, live, hit;
    hit = 1'b0;
    if (m_axis_tvalid_o && m_ready) begin
      hit = 1'b1;
      got = {m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[23:8]};
      case (got.status)
        lb32_pkg::ST_BYTE:  n_bytes++;
        lb32_pkg::ST_DONE:  n_done++;
        lb32_pkg::ST_ERROR: n_err++;
        default: ;
      endcase
      if (due_results.size() == 0) begin
        flag_error($sformatf("result beat with none due: status %0d value %0h count %0d",
                             got.status, got.value, got.count));
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status)
          flag_error($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.value !== want.value)
          flag_error($sformatf("value %0h, expected %0h", got.value, want.value));
        if (got.count !== want.count)
          flag_error($sformatf("byte_count %0d, expected %0d", got.count, want.count));
      end
    end
    if (s_valid && s_axis_tready_o) begin
      hit = 1'b1;
      beats_in++;
      decode_step(s_user, s_data, made, calc, live);
      // typed rows override the predicted beat, state still follows the predictor
      if (row_tag.typed) begin
        made = row_tag.has;
        calc = row_tag.res;
      end
      if (made) due_results.push_back(calc);
      if (live) live_items++;
    end
    if (cfg_we) cap_bytes = cfg_wdata;
    idle_cycles = hit ? 0 : idle_cycles + 1;
  end

  // a run of cycles with no beat at all means the decoder hung
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // result side: random stall bursts, none when quiet
  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (quiet) hold = 0;
      else if (hold > 0) hold--;
      else if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 18);
      m_ready <= (hold == 0);
    end
  end

  // one input beat, starting and ending at a falling edge; valid stays up between beats
  task automatic send_beat(input logic kind, input logic [7:0] ch);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_user  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // character for a digit value, random case and sometimes an alias
  function automatic logic [7:0] glyph(input logic [4:0] v);
    logic [7:0] c;
    if (v >= 5'd26) return "2" + 8'(v - 5'd26);
    c = "A" + 8'(v);
    if ($urandom_range(0, 3) == 0) begin
      if (c == "O") return "0";
      if (c == "L") return "1";
      if (c == "B") return "8";
    end
    if ($urandom_range(0, 1) == 1) c = c | 8'h20;
    return c;
  endfunction

  // one string: mostly well formed base32, some with noise or broken padding
  task automatic send_text();
    int n, pads, style;
    n     = $urandom_range(0, 16);
    style = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(lb32_pkg::KIND_CHAR, blank_chars[$urandom_range(0, 4)]);
      if (style == 7 && $urandom_range(0, 5) == 0)
        send_beat(lb32_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
      else
        send_beat(lb32_pkg::KIND_CHAR, glyph(5'($urandom_range(0, 31))));
    end
    pads = (8 - n % 8) % 8;
    if (style == 8) pads = $urandom_range(1, 8);
    else if ($urandom_range(0, 2) == 0) pads = 0;
    repeat (pads) send_beat(lb32_pkg::KIND_CHAR, CH_PAD);
    // something right after padding: fine if it closed, an error if not
    if (style == 8) begin
      if ($urandom_range(0, 1) == 1)
        send_beat(lb32_pkg::KIND_CHAR, blank_chars[$urandom_range(0, 4)]);
      else send_beat(lb32_pkg::KIND_CHAR, glyph(5'($urandom_range(0, 31))));
    end
    if (style == 9)
      repeat ($urandom_range(1, 4)) send_beat(lb32_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
    send_beat(lb32_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // sender holds off until every due result is out, then lets the pipe settle
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int caps [6];
    int goals [6];
    int start;
    caps  = '{65535, 0, 1, 3, 0, 65535};
    goals = '{40, 4, 20, 30, 60, 80};
    caps[4] = $urandom_range(2, 40);
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int r = 0; r < DIR_N; r++) begin
      row_tag <= directed[r];
      send_beat(directed[r].kind, directed[r].ch);
    end
    row_tag <= '0;

    // random strings under each max_bytes setting, last phase with no stalls
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      quiet     = (p == 5);
      cfg_we    <= 1'b1;
      cfg_wdata <= 16'(caps[p]);
      @(negedge clk_i);
      cfg_we    <= 1'b0;
      start = live_items;
      while (live_items - start < goals[p]) send_text();
    end
    wait_drained();

    $display("covered %0d input beats, max_bytes at 65535, 0, 1, 3, %0d and 65535 again",
             beats_in, caps[4]);
    $display("result beats: %0d bytes, %0d string ends, %0d errors", n_bytes, n_done, n_err);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
